[src/pfl_pkg.sv]
// ============================================================================
// Per-CPU page free-list allocator: shared package
// Sizes, field widths, result codes, register addresses and the sequencer
// state type of the allocator.
// ============================================================================
package pfl_pkg;

    // Sizing of the allocator.
    localparam int CPU_COUNT  = 8;
    localparam int PAGE_COUNT = 32768;
    localparam int PAGE_BYTES = 4096;

    // Widths that follow from the sizing and from the fixed field widths.
    localparam int ADDR_W     = 40;
    localparam int CPU_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int CPU_IDX_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int SLOT_W     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int LINK_W     = SLOT_W + 1;  // valid bit on top of a slot index

    // Stream and register port widths.
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 40;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 64;

    // Register byte addresses.
    localparam logic [PADDR_W-1:0] REG_MEM_START = 4'h0;
    localparam logic [PADDR_W-1:0] REG_MEM_STOP  = 4'h8;

    // Register reset values.
    localparam logic [ADDR_W-1:0] MEM_START_RST = 40'h00_8000_0000;
    localparam logic [ADDR_W-1:0] MEM_STOP_RST  = 40'h00_8800_0000;

    // Operation carried in the input tuser.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status carried in the output tuser.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_ALLOC   = 2'd0,
        STATUS_FREED   = 2'd1,
        STATUS_EMPTY   = 2'd2,
        STATUS_BADFREE = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_POP,
        ST_HOLD
    } state_t;

endpackage

[src/per_cpu_page_free_list_allocator_unit.sv]
// ============================================================================
// Per-CPU page free-list allocator
// Keeps one LIFO list of free pages per CPU, linked through a next-link memory,
// and serves allocate and free beats with stealing from other CPUs' lists.
// ============================================================================
// Usage.
// Requests arrive as beats on the s_ channel: s_tuser carries the operation
// (allocate or free) and s_tdata the requesting CPU and the page address.
// Every request gives exactly one result beat on the m_ channel: m_tuser holds
// the status and m_tdata the granted page address (zero unless allocated).
// The page window is set through the APB port: mem_start at byte address 0,
// mem_stop at byte address 8; it should only be changed while the block is idle.
// One request is worked at a time. The result register is loaded from the
// check state for a free (check and push) or an allocate that finds all
// lists empty, else from the pop state (pick a list, read its head's link,
// then pop). A new request is taken only once the sequencer is back in idle;
// the link memory, read through a register, is why there is a pop state.
// The result sits in an output register, so the next request is taken while a
// result still waits; if the receiver stalls when a second result is ready,
// that result is parked and s_tready stays low until it can be handed over.
// Reset empties every list at once through the head valid bits; the link
// memory needs no clearing, as a link is always written before it is read.
// Both registers return to their reset values.
// ============================================================================
module per_cpu_page_free_list_allocator_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Request channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pfl_pkg::S_TDATA_W-1:0]     s_tdata,   // cpu[2:0], page_address[42:3]
    input  logic                              s_tuser,   // mode[0]
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pfl_pkg::M_TDATA_W-1:0]     m_tdata,   // granted_address[39:0]
    output logic [pfl_pkg::STATUS_W-1:0]      m_tuser,   // status[1:0]
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pfl_pkg::PADDR_W-1:0]       paddr,
    input  logic [pfl_pkg::PDATA_W-1:0]       pwdata,
    output logic [pfl_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    localparam int AW = pfl_pkg::ADDR_W;
    localparam int BW = pfl_pkg::ADDR_W + 1;   // base may round up past the top

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [AW-1:0] mem_start_reg;
    logic [AW-1:0] mem_stop_reg;
    logic [BW-1:0] base_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_start_reg <= pfl_pkg::MEM_START_RST;
            mem_stop_reg  <= pfl_pkg::MEM_STOP_RST;
        end else if (cfg_wr) begin
            if (paddr[3] == pfl_pkg::REG_MEM_STOP[3]) begin
                mem_stop_reg <= pwdata[AW-1:0];
            end else begin
                mem_start_reg <= pwdata[AW-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[3] == pfl_pkg::REG_MEM_STOP[3]) begin
            prdata = pfl_pkg::PDATA_W'(mem_stop_reg);
        end else begin
            prdata = pfl_pkg::PDATA_W'(mem_start_reg);
        end
    end

    // Page base: mem_start rounded up to a whole page, kept in a register.
    always_ff @(posedge aclk) begin
        base_reg <= (BW'(mem_start_reg) + BW'(pfl_pkg::PAGE_BYTES - 1))
                    & ~BW'(pfl_pkg::PAGE_BYTES - 1);
    end

    // ------------------------------------------------------------------
    // List heads: one valid bit and slot index per CPU, in flip-flops.
    // ------------------------------------------------------------------
    logic                        head_valid_reg [pfl_pkg::CPU_COUNT];
    logic [pfl_pkg::SLOT_W-1:0]  head_slot_reg  [pfl_pkg::CPU_COUNT];

    // Link memory: valid bit and next slot for every page slot.
    logic [pfl_pkg::LINK_W-1:0]  link_mem [pfl_pkg::PAGE_COUNT];
    logic [pfl_pkg::LINK_W-1:0]  link_rd_reg;

    // ------------------------------------------------------------------
    // Request and sequencer registers.
    // ------------------------------------------------------------------
    pfl_pkg::state_t              state_reg, state_next;
    logic                         mode_reg;
    logic [pfl_pkg::CPU_W-1:0]    cpu_reg;
    logic [AW-1:0]                addr_reg;
    logic [pfl_pkg::CPU_IDX_W-1:0] pick_reg, pick_next;
    logic [pfl_pkg::SLOT_W-1:0]   slot_reg, slot_next;

    logic [pfl_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [AW-1:0]                res_addr_reg, res_addr_next;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [pfl_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [AW-1:0]                m_addr_reg, m_addr_next;

    logic                         s_accept;
    logic                         out_free;

    assign s_tready = (state_reg == pfl_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_addr_reg;

    // ------------------------------------------------------------------
    // Free checks and list pick, on the registered request.
    // ------------------------------------------------------------------
    logic                         cpu_ok;
    logic [pfl_pkg::CPU_IDX_W-1:0] own_idx;
    logic [BW-1:0]                diff;
    logic                         free_ok;
    logic                         steal_found;
    logic [pfl_pkg::CPU_IDX_W-1:0] steal_idx;
    logic [BW-1:0]                grant_sum;

    assign cpu_ok  = (32'(cpu_reg) < pfl_pkg::CPU_COUNT);
    assign own_idx = pfl_pkg::CPU_IDX_W'(cpu_reg);
    assign diff    = BW'(addr_reg) - base_reg;

    assign free_ok = cpu_ok
                  && (addr_reg[pfl_pkg::PAGE_SHIFT-1:0] == '0)
                  && (addr_reg >= mem_start_reg)
                  && (addr_reg < mem_stop_reg)
                  && (BW'(addr_reg) >= base_reg)
                  && ((diff >> pfl_pkg::PAGE_SHIFT) < BW'(pfl_pkg::PAGE_COUNT));

    // Lowest-numbered non-empty list other than the requester's.
    always_comb begin
        steal_found = 1'b0;
        steal_idx   = '0;
        for (int c = pfl_pkg::CPU_COUNT - 1; c >= 0; c--) begin
            if (head_valid_reg[c] && (32'(cpu_reg) != c)) begin
                steal_found = 1'b1;
                steal_idx   = pfl_pkg::CPU_IDX_W'(c);
            end
        end
    end

    // Address of the popped page: base plus slot times page size.
    assign grant_sum = base_reg + (BW'(slot_reg) << pfl_pkg::PAGE_SHIFT);

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    logic                          fin;
    logic [pfl_pkg::STATUS_W-1:0]  fin_status;
    logic [AW-1:0]                 fin_addr;
    logic                          push_en;
    logic                          pop_en;
    logic                          rd_en;

    always_comb begin
        state_next      = state_reg;
        pick_next       = pick_reg;
        slot_next       = slot_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_addr_next     = m_addr_reg;
        fin             = 1'b0;
        fin_status      = pfl_pkg::STATUS_EMPTY;
        fin_addr        = '0;
        push_en         = 1'b0;
        pop_en          = 1'b0;
        rd_en           = 1'b0;

        unique case (state_reg)
            pfl_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = pfl_pkg::ST_CHECK;
                end
            end
            pfl_pkg::ST_CHECK: begin
                if (mode_reg == pfl_pkg::MODE_FREE) begin
                    fin     = 1'b1;
                    push_en = free_ok;
                    fin_status = free_ok ? pfl_pkg::STATUS_FREED : pfl_pkg::STATUS_BADFREE;
                end else if (cpu_ok && head_valid_reg[own_idx]) begin
                    pick_next  = own_idx;
                    slot_next  = head_slot_reg[own_idx];
                    rd_en      = 1'b1;
                    state_next = pfl_pkg::ST_POP;
                end else if (steal_found) begin
                    pick_next  = steal_idx;
                    slot_next  = head_slot_reg[steal_idx];
                    rd_en      = 1'b1;
                    state_next = pfl_pkg::ST_POP;
                end else begin
                    fin        = 1'b1;
                    fin_status = pfl_pkg::STATUS_EMPTY;
                end
            end
            pfl_pkg::ST_POP: begin
                fin        = 1'b1;
                pop_en     = 1'b1;
                fin_status = pfl_pkg::STATUS_ALLOC;
                fin_addr   = grant_sum[AW-1:0];
            end
            pfl_pkg::ST_HOLD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_addr_next   = res_addr_reg;
                    state_next    = pfl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfl_pkg::ST_IDLE;
            end
        endcase

        // A finished result goes straight out, or is parked if the receiver stalls.
        if (fin) begin
            if (out_free) begin
                m_tvalid_next = 1'b1;
                m_status_next = fin_status;
                m_addr_next   = fin_addr;
                state_next    = pfl_pkg::ST_IDLE;
            end else begin
                res_status_next = fin_status;
                res_addr_next   = fin_addr;
                state_next      = pfl_pkg::ST_HOLD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pfl_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode_reg <= s_tuser;
            cpu_reg  <= s_tdata[pfl_pkg::CPU_W-1:0];
            addr_reg <= s_tdata[pfl_pkg::CPU_W +: AW];
        end
        pick_reg       <= pick_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        m_status_reg   <= m_status_next;
        m_addr_reg     <= m_addr_next;
    end

    // ------------------------------------------------------------------
    // Head updates: a push makes the freed slot the head, a pop follows
    // the link read in the previous cycle.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < pfl_pkg::CPU_COUNT; c++) begin
                head_valid_reg[c] <= 1'b0;
            end
        end else if (push_en) begin
            head_valid_reg[own_idx] <= 1'b1;
        end else if (pop_en) begin
            head_valid_reg[pick_reg] <= link_rd_reg[pfl_pkg::SLOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            head_slot_reg[own_idx] <= diff[pfl_pkg::PAGE_SHIFT +: pfl_pkg::SLOT_W];
        end else if (pop_en) begin
            head_slot_reg[pick_reg] <= link_rd_reg[pfl_pkg::SLOT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Link memory: one write or one read per cycle, read data registered.
    // Accesses never overlap, as one request is worked at a time.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (push_en) begin
            link_mem[diff[pfl_pkg::PAGE_SHIFT +: pfl_pkg::SLOT_W]] <=
                {head_valid_reg[own_idx], head_slot_reg[own_idx]};
        end
        if (rd_en) begin
            link_rd_reg <= link_mem[slot_next];
        end
    end

endmodule

[src/pfl_checker.sv]
// ============================================================================
// Per-CPU page free-list allocator: port checker
// Concurrent assertions on the top level's ports, attached by a bind.
// ============================================================================
module pfl_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pfl_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [pfl_pkg::STATUS_W-1:0]  m_tuser
);

    // A stalled result beat keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Only an allocation carries a page address.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != pfl_pkg::STATUS_ALLOC) |-> (m_tdata == '0))
        else $error("non-allocation result carries an address");

    // Reset leaves no result beat pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // Requests are worked one at a time: no two accepted in successive cycles.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in work");

    // With no result waiting, a free's result comes from the check state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == pfl_pkg::MODE_FREE) && !m_tvalid
        |=> ##1 m_tvalid
            && (m_tuser == pfl_pkg::STATUS_FREED || m_tuser == pfl_pkg::STATUS_BADFREE))
        else $error("free result missing or wrong kind");

endmodule

bind per_cpu_page_free_list_allocator_unit pfl_checker u_pfl_checker (.*);

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// Testbench for the per-CPU page free-list allocator
// Sends allocate and free beats with random stalls on both stream channels,
// predicts every result with a cycle-free model of the per-CPU lists and
// checks each result beat against the oldest prediction. The page window is
// moved through the APB port between phases, from the reset window out to
// both ends of the address range.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfl_pkg::*;

    // One request as it travels on the s_ channel.
    typedef struct packed {
        logic              op;
        logic [CPU_W-1:0]  cpu;
        logic [ADDR_W-1:0] addr;
    } page_req_t;

    // One predicted result beat.
    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] granted;
    } page_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;    // cpu[2:0], page_address[42:3], zero pad
    logic                 s_tuser = 1'b0;  // mode[0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // granted_address[39:0]
    logic [STATUS_W-1:0]  m_tuser;         // status[1:0]
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    per_cpu_page_free_list_allocator_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Shadow of the allocator: the window registers, one head per CPU and one
    // next link per page slot. A clear valid bit marks an empty list or the
    // end of a list.
    // ------------------------------------------------------------------------
    logic [ADDR_W-1:0] cfg_start = MEM_START_RST;
    logic [ADDR_W-1:0] cfg_stop  = MEM_STOP_RST;
    bit                head_ok   [CPU_COUNT];
    logic [SLOT_W-1:0] head_slot [CPU_COUNT];
    bit                link_ok   [PAGE_COUNT];
    logic [SLOT_W-1:0] link_slot [PAGE_COUNT];

    page_req_t         req_q[$];            // requests not yet put on the bus
    page_result_t      grant_expect_q[$];   // results owed by the block, oldest first
    logic [ADDR_W-1:0] granted_pages[$];    // pages handed out, used for later frees

    int unsigned s_idle_pct = 0;
    int unsigned m_idle_pct = 0;
    bit          s_beat_taken = 1'b0;
    page_req_t   drv_req;
    int          n_errors = 0;
    int          n_requests = 0;
    int          n_granted = 0;
    int          n_stolen = 0;
    int          n_empty = 0;
    int          n_freed = 0;
    int          n_rejected = 0;

    // First page address of the window: mem_start rounded up to a whole page.
    // Kept at 64 bits, as the rounding can carry past the top of the bus.
    function automatic logic [63:0] window_base();
        logic [63:0] s64;
        s64 = {{(64-ADDR_W){1'b0}}, cfg_start} + 64'(PAGE_BYTES - 1);
        return (s64 >> PAGE_SHIFT) << PAGE_SHIFT;
    endfunction

    function automatic bit take_head(input int c, output logic [SLOT_W-1:0] slot);
        if (!head_ok[c]) begin
            return 1'b0;
        end
        slot = head_slot[c];
        head_ok[c] = link_ok[slot];
        head_slot[c] = link_slot[slot];
        return 1'b1;
    endfunction

    // Works out the result of one accepted request and updates the shadow.
    function automatic page_result_t serve_request(input logic op, input logic [CPU_W-1:0] cpu,
                                                   input logic [ADDR_W-1:0] addr);
        page_result_t      res;
        logic [63:0]       base;
        logic [63:0]       a64;
        logic [63:0]       idx;
        logic [63:0]       g64;
        logic [SLOT_W-1:0] slot;
        bit                got;
        int                c;
        base = window_base();
        a64 = {{(64-ADDR_W){1'b0}}, addr};
        idx = (a64 - base) >> PAGE_SHIFT;
        res.status = STATUS_EMPTY;
        res.granted = '0;
        got = 1'b0;
        slot = '0;
        if (op == MODE_FREE) begin
            // A free must be page aligned, inside [mem_start, mem_stop), at or
            // above the rounded base and within the page store.
            if (cpu < CPU_COUNT && addr[PAGE_SHIFT-1:0] == '0 && addr >= cfg_start &&
                addr < cfg_stop && a64 >= base && idx < PAGE_COUNT) begin
                slot = idx[SLOT_W-1:0];
                link_ok[slot] = head_ok[cpu];
                link_slot[slot] = head_slot[cpu];
                head_ok[cpu] = 1'b1;
                head_slot[cpu] = slot;
                res.status = STATUS_FREED;
                n_freed++;
            end else begin
                res.status = STATUS_BADFREE;
                n_rejected++;
            end
        end else begin
            // Own list first, then the others in ascending order.
            if (cpu < CPU_COUNT) begin
                got = take_head(cpu, slot);
            end
            for (c = 0; c < CPU_COUNT && !got; c++) begin
                if (c != cpu) begin
                    got = take_head(c, slot);
                    if (got) begin
                        n_stolen++;
                    end
                end
            end
            if (got) begin
                g64 = base + ({{(64-SLOT_W){1'b0}}, slot} << PAGE_SHIFT);
                res.status = STATUS_ALLOC;
                res.granted = g64[ADDR_W-1:0];
                if (granted_pages.size() < 256) begin
                    granted_pages.push_back(res.granted);
                end
                n_granted++;
            end else begin
                n_empty++;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. Inputs change on the falling edge; a beat is held until
    // the rising edge that takes it, then the next one is offered or the
    // channel idles.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_beat_taken) begin
            if (req_q.size() != 0 && $urandom_range(99) >= s_idle_pct) begin
                drv_req = req_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= drv_req.op;
                s_tdata <= {{(S_TDATA_W-ADDR_W-CPU_W){1'b0}}, drv_req.addr, drv_req.cpu};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: stalls at random according to the current phase.
    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= m_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor. On each rising edge a taken result beat is checked against the
    // oldest prediction, and a taken request beat is run through the shadow.
    // A result can never leave in the same cycle as its own request enters,
    // so the order of the two steps does not matter.
    // ------------------------------------------------------------------------
    page_result_t want;

    always @(posedge aclk) begin
        s_beat_taken = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (grant_expect_q.size() == 0) begin
                    $display("%0t: result beat with none owed, status %0d address %h",
                             $time, m_tuser, m_tdata);
                    n_errors++;
                end else begin
                    want = grant_expect_q.pop_front();
                    if (m_tuser !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, m_tuser);
                        n_errors++;
                    end
                    if (m_tdata !== want.granted) begin
                        $display("%0t: granted address mismatch, expected %h, actual %h",
                                 $time, want.granted, m_tdata);
                        n_errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                s_beat_taken = 1'b1;
                n_requests++;
                grant_expect_q.push_back(serve_request(s_tuser, s_tdata[CPU_W-1:0],
                                                       s_tdata[CPU_W+ADDR_W-1:CPU_W]));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    task automatic push_req(input logic op, input int cpu, input logic [ADDR_W-1:0] addr);
        page_req_t r;
        r.op = op;
        r.cpu = cpu[CPU_W-1:0];
        r.addr = addr;
        req_q.push_back(r);
    endtask

    // Blocks until every request has gone out and every result has come back.
    task automatic wait_drain();
        while (req_q.size() != 0 || s_tvalid || grant_expect_q.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // One APB transfer: a setup phase, then an access phase that completes on
    // the rising edge where pready is high.
    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] a,
                              input logic [PDATA_W-1:0] d, output logic [PDATA_W-1:0] rd);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= a;
        pwdata <= d;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        rd = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Moves the page window while the block is quiet, then reads both
    // registers back.
    task automatic set_window(input logic [ADDR_W-1:0] start, input logic [ADDR_W-1:0] stop);
        logic [PDATA_W-1:0] rd;
        wait_drain();
        repeat (4) @(negedge aclk);
        apb_access(1'b1, REG_MEM_START, {{(PDATA_W-ADDR_W){1'b0}}, start}, rd);
        cfg_start = start;
        apb_access(1'b1, REG_MEM_STOP, {{(PDATA_W-ADDR_W){1'b0}}, stop}, rd);
        cfg_stop = stop;
        apb_access(1'b0, REG_MEM_START, '0, rd);
        if (rd[ADDR_W-1:0] !== start) begin
            $display("%0t: mem_start read back mismatch, expected %h, actual %h",
                     $time, start, rd[ADDR_W-1:0]);
            n_errors++;
        end
        apb_access(1'b0, REG_MEM_STOP, '0, rd);
        if (rd[ADDR_W-1:0] !== stop) begin
            $display("%0t: mem_stop read back mismatch, expected %h, actual %h",
                     $time, stop, rd[ADDR_W-1:0]);
            n_errors++;
        end
        // Pages handed out under the old window no longer sit at the same
        // addresses, so they are not reused for frees.
        granted_pages.delete();
    endtask

    // Picks an address for a random free. Mostly a page handed out earlier,
    // otherwise a page of the window, an edge of the window, a misaligned
    // address or anything at all.
    function automatic logic [ADDR_W-1:0] pick_free_address();
        logic [63:0] base;
        logic [63:0] a64;
        logic [63:0] span;
        int unsigned slots;
        int unsigned r;
        int unsigned k;
        base = window_base();
        span = ({{(64-ADDR_W){1'b0}}, cfg_stop} > base) ?
               ({{(64-ADDR_W){1'b0}}, cfg_stop} - base + 64'(PAGE_BYTES - 1)) >> PAGE_SHIFT : 64'd1;
        slots = (span > 64) ? 64 : int'(span);
        r = $urandom_range(99);
        a64 = {$urandom, $urandom};
        if (r < 70 && granted_pages.size() != 0) begin
            k = $urandom_range(granted_pages.size() - 1);
            a64[ADDR_W-1:0] = granted_pages[k];
            granted_pages.delete(k);
        end else if (r < 80) begin
            a64 = base + (64'($urandom_range(slots - 1)) << PAGE_SHIFT);
        end else if (r < 88) begin
            case ($urandom_range(7))
                0: a64 = {{(64-ADDR_W){1'b0}}, cfg_start};
                1: a64 = base - 64'(PAGE_BYTES);
                2: a64 = {{(64-ADDR_W){1'b0}}, cfg_stop};
                3: a64 = ({{(64-ADDR_W){1'b0}}, cfg_stop} - 64'd1) >> PAGE_SHIFT << PAGE_SHIFT;
                4: a64 = base + (64'(PAGE_COUNT - 1) << PAGE_SHIFT);
                5: a64 = base + (64'(PAGE_COUNT) << PAGE_SHIFT);
                6: a64 = '0;
                default: a64 = {{(64-ADDR_W){1'b0}}, {(ADDR_W-PAGE_SHIFT){1'b1}},
                                {PAGE_SHIFT{1'b0}}};
            endcase
        end else if (r < 94) begin
            a64 = base + (64'($urandom_range(slots - 1)) << PAGE_SHIFT)
                  + 64'($urandom_range(PAGE_BYTES - 1, 1));
        end
        return a64[ADDR_W-1:0];
    endfunction

    // Random requests in runs of forty, each run with its own mix of frees and
    // allocates so that the lists both fill up and run dry. Requests are made
    // only a couple of beats ahead, so frees can reuse pages just granted.
    task automatic run_random(input int count);
        int          i;
        int unsigned free_pct;
        logic [63:0] r64;
        free_pct = 50;
        for (i = 0; i < count; i++) begin
            while (req_q.size() >= 2) begin
                @(negedge aclk);
            end
            if (i % 40 == 0) begin
                case ($urandom_range(2))
                    0: free_pct = 20;
                    1: free_pct = 50;
                    default: free_pct = 80;
                endcase
            end
            r64 = {$urandom, $urandom};
            if ($urandom_range(99) < free_pct) begin
                push_req(MODE_FREE, $urandom_range(CPU_COUNT - 1), pick_free_address());
            end else begin
                push_req(MODE_ALLOC, $urandom_range(CPU_COUNT - 1), r64[ADDR_W-1:0]);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Sender idles in about a third of the cycles, receiver in two thirds.
        s_idle_pct = 31;
        m_idle_pct = 69;

        // Directed part, in the reset window. Empty lists, LIFO order, the
        // last page slot, a misaligned free and frees outside the window,
        // stealing in ascending CPU order and the same page freed onto two lists.
        push_req(MODE_ALLOC, 0, '0);
        push_req(MODE_FREE,  0, MEM_START_RST);
        push_req(MODE_FREE,  0, MEM_START_RST + 40'h1000);
        push_req(MODE_ALLOC, 0, '0);
        push_req(MODE_FREE,  7, MEM_STOP_RST - 40'h1000);
        push_req(MODE_FREE,  3, MEM_START_RST + 40'h800);
        push_req(MODE_FREE,  3, MEM_START_RST - 40'h1000);
        push_req(MODE_FREE,  3, MEM_STOP_RST);
        push_req(MODE_FREE,  3, 40'hFF_FFFF_F000);
        push_req(MODE_FREE,  3, '0);
        push_req(MODE_ALLOC, 5, '0);
        push_req(MODE_ALLOC, 5, '0);
        push_req(MODE_ALLOC, 2, '0);
        push_req(MODE_FREE,  1, MEM_START_RST + 40'h2000);
        push_req(MODE_FREE,  2, MEM_START_RST + 40'h2000);
        push_req(MODE_ALLOC, 1, '0);
        push_req(MODE_ALLOC, 2, '0);
        push_req(MODE_ALLOC, 4, '0);
        push_req(MODE_FREE,  6, MEM_START_RST + 40'h3000);
        push_req(MODE_FREE,  4, MEM_START_RST + 40'h4000);
        push_req(MODE_ALLOC, 0, '0);
        push_req(MODE_ALLOC, 6, '0);
        push_req(MODE_ALLOC, 7, 40'hFF_FFFF_FFFF);

        // Whole address range open: base zero, top of the page store inside.
        set_window('0, 40'hFF_FFFF_FFFF);
        run_random(260);
        // The sender holds off until every owed result has arrived.
        wait_drain();
        run_random(260);

        // Roles swapped: the sender idles more than the receiver. Unaligned
        // start and stop, with the stop cutting the last page of the window.
        s_idle_pct = 69;
        m_idle_pct = 31;
        set_window(40'h12_3456_7890, 40'h12_3459_8800);
        run_random(520);

        // No idling from here on. A start so close to the top that the base
        // rounds past the bus: every free is refused, grants wrap round past zero.
        s_idle_pct = 0;
        m_idle_pct = 0;
        set_window(40'hFF_FFFF_F001, 40'hFF_FFFF_FFFF);
        run_random(80);
        // Window ending at the top of the address range.
        set_window(40'hFF_FFF0_0000, 40'hFF_FFFF_FFFF);
        run_random(420);

        wait_drain();
        repeat (8) @(posedge aclk);
        $display("Summary: %0d requests over five page windows: %0d grants, %0d of them stolen, %0d found every list empty.",
                 n_requests, n_granted, n_stolen, n_empty);
        $display("Summary: %0d pages freed, %0d frees refused, %0d mismatches.",
                 n_freed, n_rejected, n_errors);
        if (n_errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("Timeout: %0d results still owed.", grant_expect_q.size());
        $display("tb failed");
        $finish;
    end

endmodule

[files.f]
src/pfl_pkg.sv
src/per_cpu_page_free_list_allocator_unit.sv
src/pfl_checker.sv
tb/sv/tb.sv
